FILE: hdl/spk_pkg.sv
// spk_pkg: shared types and constants for the speck block cipher engine
// no dependencies; used by the top level and the checker

package spk_pkg;

   localparam int FIELD_BITS     = 32;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic MODE_ENC = 1'b0;
   localparam logic MODE_DEC = 1'b1;

   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;

   localparam csr_index_type CSR_KEY_WORD_0    = 3'd0;
   localparam csr_index_type CSR_KEY_WORD_1    = 3'd1;
   localparam csr_index_type CSR_KEY_WORD_2    = 3'd2;
   localparam csr_index_type CSR_KEY_WORD_3    = 3'd3;
   localparam csr_index_type CSR_NUM_KEY_WORDS = 3'd4;
   localparam csr_index_type CSR_NUM_ROUNDS    = 3'd5;
   localparam csr_index_type CSR_ROT_ALPHA     = 3'd6;
   localparam csr_index_type CSR_ROT_BETA      = 3'd7;

   localparam logic [2:0] KEY_WORDS_RESET = 3'd4;
   localparam logic [5:0] ROUNDS_RESET    = 6'd27;
   localparam logic [5:0] ALPHA_RESET     = 6'd8;
   localparam logic [5:0] BETA_RESET      = 6'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXPAND,
      ST_FETCH,
      ST_ROUND,
      ST_FINISH
   } seq_state_type;

endpackage

FILE: hdl/spk_round_unit.sv
// spk_round_unit: one speck round, forward or inverse, on two words
// depends on nothing but its parameter; used by speck_block_cipher

module spk_round_unit #(
   parameter int WORD_BITS = 32,
   localparam int SHW = $clog2(WORD_BITS)
) (
   input  logic                 dec,
   input  logic [WORD_BITS-1:0] x_in,
   input  logic [WORD_BITS-1:0] y_in,
   input  logic [WORD_BITS-1:0] key,
   input  logic [SHW-1:0]       alpha,
   input  logic [SHW-1:0]       beta,
   output logic [WORD_BITS-1:0] x_out,
   output logic [WORD_BITS-1:0] y_out
);

   function automatic logic [WORD_BITS-1:0] rotr(input logic [WORD_BITS-1:0] v,
                                                 input logic [SHW-1:0] s);
      logic [2*WORD_BITS-1:0] d;
      d = {v, v} >> s;
      return d[WORD_BITS-1:0];
   endfunction

   function automatic logic [WORD_BITS-1:0] rotl(input logic [WORD_BITS-1:0] v,
                                                 input logic [SHW-1:0] s);
      logic [2*WORD_BITS-1:0] d;
      d = {v, v} << s;
      return d[2*WORD_BITS-1:WORD_BITS];
   endfunction

   logic [WORD_BITS-1:0] enc_x;
   logic [WORD_BITS-1:0] enc_y;
   logic [WORD_BITS-1:0] dec_x;
   logic [WORD_BITS-1:0] dec_y;

   always_comb begin
      enc_x = (rotr(x_in, alpha) + y_in) ^ key;
      enc_y = rotl(y_in, beta) ^ enc_x;
      dec_y = rotr(y_in ^ x_in, beta);
      dec_x = rotl((x_in ^ key) - dec_y, alpha);
   end

   assign x_out = dec ? dec_x : enc_x;
   assign y_out = dec ? dec_y : enc_y;

endmodule

FILE: hdl/speck_block_cipher.sv
// speck_block_cipher: speck block cipher engine with on-chip key expansion
// uses spk_pkg and spk_round_unit
//
// One shared round unit does one round per cycle, both for the key schedule and for the
// block. A block runs from accept through a round-key memory read ahead, the rounds and
// the load of the output register, which waits while an untaken result is held; a new
// request is taken only once the block is back in idle. After reset or any register
// write the next request first runs the key schedule, writing the round-key memory one
// entry a cycle. Decrypt reads the round keys in reverse. The result register lets the
// next request be accepted while a result waits.

module speck_block_cipher #(
   parameter int WORD_BITS     = 32,
   parameter int MAX_ROUNDS    = 34,
   parameter int MAX_KEY_WORDS = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_mode,
   input  logic [spk_pkg::FIELD_BITS-1:0]     req_x_word,
   input  logic [spk_pkg::FIELD_BITS-1:0]     req_y_word,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [spk_pkg::FIELD_BITS-1:0]     rsp_x_result,
   output logic [spk_pkg::FIELD_BITS-1:0]     rsp_y_result,
   input  logic                               csr_wr_en,
   input  spk_pkg::csr_index_type             csr_index,
   input  logic [spk_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int SHW = $clog2(WORD_BITS);
   localparam int CW  = $clog2(MAX_ROUNDS + 1);
   localparam int AW  = $clog2(MAX_ROUNDS);
   localparam int SW  = MAX_KEY_WORDS - 1;

   function automatic logic [SHW-1:0] rot_reduce(input logic [5:0] r);
      logic [6:0] v;
      v = {1'b0, r};
      for (int k = 0; k < 4; k++) begin
         if (v >= 7'(WORD_BITS)) begin
            v = v - 7'(WORD_BITS);
         end
      end
      return SHW'(v);
   endfunction

   // configuration registers
   logic [spk_pkg::FIELD_BITS-1:0] key_ff [4];
   logic [2:0]                     num_key_words_ff;
   logic [5:0]                     num_rounds_ff;
   logic [SHW-1:0]                 alpha_ff;
   logic [SHW-1:0]                 beta_ff;
   logic                           sched_ready_ff;

   // sequencer and datapath
   spk_pkg::seq_state_type state_ff;
   spk_pkg::seq_state_type state_in;
   logic [CW-1:0]          cnt_ff;
   logic [CW-1:0]          cnt_next;
   logic [WORD_BITS-1:0]   x_ff;
   logic [WORD_BITS-1:0]   y_ff;
   logic                   dec_ff;
   logic [WORD_BITS-1:0]   rk_cur_ff;
   logic [WORD_BITS-1:0]   sched_ff [SW];
   logic [WORD_BITS-1:0]   sched_shift [SW];
   logic [WORD_BITS-1:0]   rk_mem [MAX_ROUNDS];
   logic [WORD_BITS-1:0]   rk_rd_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [spk_pkg::FIELD_BITS-1:0] rsp_x_result_ff;
   logic [spk_pkg::FIELD_BITS-1:0] rsp_y_result_ff;

   logic           req_fire;
   logic           load_block;
   logic           exp_init;
   logic           exp_step;
   logic           exp_done;
   logic           round_step;
   logic           rsp_load;
   logic           cnt_clear;
   logic           rounds_zero;
   logic [2:0]     m_eff;
   logic [CW-1:0]  t_eff;
   logic [6:0]     rounds_raw;
   logic           mem_we;
   logic [AW-1:0]  mem_waddr;
   logic [WORD_BITS-1:0] mem_wdata;
   logic [CW-1:0]  rd_idx;
   logic [AW-1:0]  mem_raddr;

   logic                 exp_mode;
   logic                 rnd_dec;
   logic [WORD_BITS-1:0] rnd_x_in;
   logic [WORD_BITS-1:0] rnd_y_in;
   logic [WORD_BITS-1:0] rnd_key;
   logic [WORD_BITS-1:0] rnd_x_out;
   logic [WORD_BITS-1:0] rnd_y_out;

   // effective key word count and round count
   always_comb begin
      if (num_key_words_ff < 3'd2) begin
         m_eff = 3'd2;
      end else if (num_key_words_ff > 3'(MAX_KEY_WORDS)) begin
         m_eff = 3'(MAX_KEY_WORDS);
      end else begin
         m_eff = num_key_words_ff;
      end
      rounds_raw = {1'b0, num_rounds_ff};
      if (rounds_raw > 7'(MAX_ROUNDS)) begin
         t_eff = CW'(MAX_ROUNDS);
      end else begin
         t_eff = CW'(rounds_raw);
      end
   end

   assign rounds_zero = (t_eff == '0);
   assign cnt_next    = cnt_ff + CW'(1);
   assign req_ready   = (state_ff == spk_pkg::ST_IDLE);
   assign req_fire    = req_valid & req_ready;

   // configuration port
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 4; k++) begin
            key_ff[k] <= '0;
         end
         num_key_words_ff <= spk_pkg::KEY_WORDS_RESET;
         num_rounds_ff    <= spk_pkg::ROUNDS_RESET;
         alpha_ff         <= rot_reduce(spk_pkg::ALPHA_RESET);
         beta_ff          <= rot_reduce(spk_pkg::BETA_RESET);
      end else if (csr_wr_en) begin
         case (csr_index)
            spk_pkg::CSR_KEY_WORD_0:    key_ff[0] <= csr_wdata;
            spk_pkg::CSR_KEY_WORD_1:    key_ff[1] <= csr_wdata;
            spk_pkg::CSR_KEY_WORD_2:    key_ff[2] <= csr_wdata;
            spk_pkg::CSR_KEY_WORD_3:    key_ff[3] <= csr_wdata;
            spk_pkg::CSR_NUM_KEY_WORDS: num_key_words_ff <= csr_wdata[2:0];
            spk_pkg::CSR_NUM_ROUNDS:    num_rounds_ff <= csr_wdata[5:0];
            spk_pkg::CSR_ROT_ALPHA:     alpha_ff <= rot_reduce(csr_wdata[5:0]);
            spk_pkg::CSR_ROT_BETA:      beta_ff <= rot_reduce(csr_wdata[5:0]);
            default: ;
         endcase
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= spk_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      load_block = 1'b0;
      exp_init   = 1'b0;
      exp_step   = 1'b0;
      exp_done   = 1'b0;
      round_step = 1'b0;
      rsp_load   = 1'b0;
      cnt_clear  = 1'b0;
      case (state_ff)
         spk_pkg::ST_IDLE: begin
            if (req_fire) begin
               load_block = 1'b1;
               cnt_clear  = 1'b1;
               if (!sched_ready_ff) begin
                  exp_init = 1'b1;
                  state_in = spk_pkg::ST_EXPAND;
               end else if (rounds_zero) begin
                  state_in = spk_pkg::ST_FINISH;
               end else begin
                  state_in = spk_pkg::ST_FETCH;
               end
            end
         end
         spk_pkg::ST_EXPAND: begin
            if (cnt_next < t_eff) begin
               exp_step = 1'b1;
            end else begin
               exp_done  = 1'b1;
               cnt_clear = 1'b1;
               state_in  = rounds_zero ? spk_pkg::ST_FINISH : spk_pkg::ST_FETCH;
            end
         end
         spk_pkg::ST_FETCH: begin
            state_in = spk_pkg::ST_ROUND;
         end
         spk_pkg::ST_ROUND: begin
            round_step = 1'b1;
            if (cnt_next == t_eff) begin
               state_in = spk_pkg::ST_FINISH;
            end
         end
         spk_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = spk_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = spk_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff         <= '0;
         sched_ready_ff <= 1'b0;
      end else begin
         if (cnt_clear) begin
            cnt_ff <= '0;
         end else if (exp_step || round_step) begin
            cnt_ff <= cnt_next;
         end
         if (csr_wr_en) begin
            sched_ready_ff <= 1'b0;
         end else if (exp_done) begin
            sched_ready_ff <= 1'b1;
         end
      end
   end

   // shared round unit: key schedule step or block round
   assign exp_mode = (state_ff == spk_pkg::ST_EXPAND);
   assign rnd_dec  = exp_mode ? spk_pkg::MODE_ENC : dec_ff;
   assign rnd_x_in = exp_mode ? sched_ff[0] : x_ff;
   assign rnd_y_in = exp_mode ? rk_cur_ff : y_ff;
   assign rnd_key  = exp_mode ? WORD_BITS'(cnt_ff) : rk_rd_ff;

   spk_round_unit #(
      .WORD_BITS (WORD_BITS)
   ) u_round (
      .dec   (rnd_dec),
      .x_in  (rnd_x_in),
      .y_in  (rnd_y_in),
      .key   (rnd_key),
      .alpha (alpha_ff),
      .beta  (beta_ff),
      .x_out (rnd_x_out),
      .y_out (rnd_y_out)
   );

   // schedule word window, new word lands at position m - 2
   always_comb begin
      for (int j = 0; j < SW; j++) begin
         if (3'(j + 2) == m_eff) begin
            sched_shift[j] = rnd_x_out;
         end else begin
            sched_shift[j] = sched_ff[(j + 1 < SW) ? j + 1 : j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_block) begin
         x_ff   <= WORD_BITS'(req_x_word);
         y_ff   <= WORD_BITS'(req_y_word);
         dec_ff <= (req_mode == spk_pkg::MODE_DEC);
      end else if (round_step) begin
         x_ff <= rnd_x_out;
         y_ff <= rnd_y_out;
      end
      if (exp_init) begin
         rk_cur_ff <= WORD_BITS'(key_ff[0]);
         for (int j = 0; j < SW; j++) begin
            sched_ff[j] <= WORD_BITS'(key_ff[j + 1]);
         end
      end else if (exp_step) begin
         rk_cur_ff <= rnd_y_out;
         for (int j = 0; j < SW; j++) begin
            sched_ff[j] <= sched_shift[j];
         end
      end
   end

   // round-key memory
   assign mem_we    = exp_init | exp_step;
   assign mem_waddr = exp_init ? '0 : AW'(cnt_next);
   assign mem_wdata = exp_init ? WORD_BITS'(key_ff[0]) : rnd_y_out;
   assign rd_idx    = (state_ff == spk_pkg::ST_FETCH) ? '0 : cnt_next;

   always_comb begin
      if (rd_idx >= t_eff) begin
         mem_raddr = '0;
      end else if (dec_ff) begin
         mem_raddr = AW'(t_eff - CW'(1) - rd_idx);
      end else begin
         mem_raddr = AW'(rd_idx);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         rk_mem[mem_waddr] <= mem_wdata;
      end
      rk_rd_ff <= rk_mem[mem_raddr];
   end

   // result register
   assign rsp_valid_in = rsp_load | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_x_result_ff <= spk_pkg::FIELD_BITS'(x_ff);
         rsp_y_result_ff <= spk_pkg::FIELD_BITS'(y_ff);
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_x_result = rsp_x_result_ff;
   assign rsp_y_result = rsp_y_result_ff;

endmodule

FILE: hdl/spk_checker.sv
// spk_checker: port-level checks on speck_block_cipher, bound to the top level
// uses spk_pkg for the field width

module spk_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [spk_pkg::FIELD_BITS-1:0]     rsp_x_result,
   input logic [spk_pkg::FIELD_BITS-1:0]     rsp_y_result
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_x_result)
                                  && $stable(rsp_y_result))
      else $error("result changed while stalled");

   // busy after a request is taken
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after request");

   // returning to ready always comes with a fresh result
   a_done_result: assert property (@(posedge clock) disable iff (reset)
      $rose(req_ready) |-> rsp_valid)
      else $error("ready again without result");

   // no result the cycle after a request
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> !rsp_valid)
      else $error("result too early");

endmodule

bind speck_block_cipher spk_checker u_spk_checker (.*);
